@@ rtl/ils_pkg.sv @@
package ils_pkg;

    localparam int DEF_CAPACITY  = 32;
    localparam int DEF_WORD_BITS = 64;
    localparam int MAX_RESULTS   = 32;

    localparam int KIND_W   = 3;
    localparam int ITEM_W   = 64;
    localparam int POS_W    = 6;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 6;

    localparam logic [KIND_W-1:0] KIND_ADD    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_INSERT = 3'd1;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd2;
    localparam logic [KIND_W-1:0] KIND_POP    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd4;
    localparam logic [KIND_W-1:0] KIND_WALK   = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd3;

    typedef enum logic [1:0] {
        WA_COUNT,
        WA_POS,
        WA_IDX
    } wsel_t;

    typedef enum logic [1:0] {
        RA_IDX,
        RA_IDX_DN,
        RA_IDX_UP,
        RA_CNT_DN
    } rsel_t;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC,
        CNT_CLR
    } cnt_op_t;

    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_LOAD_CNT,
        IDX_LOAD_POS,
        IDX_ZERO,
        IDX_INC,
        IDX_DEC
    } idx_op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_UP_RD,
        S_UP_WR,
        S_DN_RD,
        S_DN_WR,
        S_POP,
        S_WALK_RD,
        S_WALK_OUT
    } state_t;

    typedef struct packed {
        logic                load_in;
        logic                wr_en;
        wsel_t               wsel;
        logic                rd_en;
        rsel_t               rsel;
        cnt_op_t             cnt_op;
        idx_op_t             idx_op;
        logic                emit;
        logic                emit_data;
        logic [STATUS_W-1:0] status;
        logic                last;
    } ils_cmd_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              full;
        logic              empty;
        logic              pos_over;
        logic              pos_out;
        logic              up_done;
        logic              dn_done;
        logic              walk_last;
        logic              out_free;
    } ils_stat_t;

endpackage

@@ rtl/indexed_list_store.sv @@
// Channel  Direction  Handshake          Word
// s_       in         s_valid/s_ready    s_kind, s_item, s_position
// m_       out        m_valid/m_ready    m_item_out, m_status, m_count, m_last
//
// One input word is taken at a time; add, clear and rejected words go through
// the accept and decide states, and pop adds a state for the registered RAM read.
// Insert and remove add a read and a write state for each entry moved, a walk a
// read and an output state per entry emitted, all via the single RAM read port.
// Reset is synchronous and active low; it empties the list at once.
// A stalled result holds in the output register while the next word is taken.
module indexed_list_store #(
    parameter int CAPACITY  = ils_pkg::DEF_CAPACITY,
    parameter int WORD_BITS = ils_pkg::DEF_WORD_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [ils_pkg::KIND_W-1:0]    s_kind,
    input  logic [ils_pkg::ITEM_W-1:0]    s_item,
    input  logic [ils_pkg::POS_W-1:0]     s_position,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [ils_pkg::ITEM_W-1:0]    m_item_out,
    output logic [ils_pkg::STATUS_W-1:0]  m_status,
    output logic [ils_pkg::COUNT_W-1:0]   m_count,
    output logic                          m_last
);

    import ils_pkg::*;

    ils_cmd_t  cmd;
    ils_stat_t stat;

    ils_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    ils_dp #(
        .CAPACITY  (CAPACITY),
        .WORD_BITS (WORD_BITS)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_kind     (s_kind),
        .s_item     (s_item),
        .s_position (s_position),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_item_out (m_item_out),
        .m_status   (m_status),
        .m_count    (m_count),
        .m_last     (m_last),
        .cmd        (cmd),
        .stat       (stat)
    );

endmodule

@@ rtl/ils_ram.sv @@
module ils_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/ils_ctrl.sv @@
module ils_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  ils_pkg::ils_stat_t stat,
    output ils_pkg::ils_cmd_t  cmd
);

    import ils_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.last   = 1'b1;
        s_ready    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready     = 1'b1;
                cmd.load_in = s_valid;
                if (s_valid) begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (stat.out_free) begin
                    state_next = S_IDLE;
                    case (stat.kind)
                        KIND_ADD: begin
                            cmd.emit = 1'b1;
                            if (stat.full) begin
                                cmd.status = ST_FULL;
                            end else begin
                                cmd.wr_en  = 1'b1;
                                cmd.wsel   = WA_COUNT;
                                cmd.cnt_op = CNT_INC;
                                cmd.status = ST_OK;
                            end
                        end
                        KIND_INSERT: begin
                            if (stat.pos_over) begin
                                cmd.emit   = 1'b1;
                                cmd.status = ST_BAD_INDEX;
                            end else if (stat.full) begin
                                cmd.emit   = 1'b1;
                                cmd.status = ST_FULL;
                            end else begin
                                cmd.idx_op = IDX_LOAD_CNT;
                                state_next = S_UP_RD;
                            end
                        end
                        KIND_REMOVE: begin
                            if (stat.pos_out) begin
                                cmd.emit   = 1'b1;
                                cmd.status = ST_BAD_INDEX;
                            end else begin
                                cmd.idx_op = IDX_LOAD_POS;
                                state_next = S_DN_RD;
                            end
                        end
                        KIND_POP: begin
                            if (stat.empty) begin
                                cmd.emit   = 1'b1;
                                cmd.status = ST_EMPTY;
                            end else begin
                                cmd.rd_en  = 1'b1;
                                cmd.rsel   = RA_CNT_DN;
                                cmd.cnt_op = CNT_DEC;
                                state_next = S_POP;
                            end
                        end
                        KIND_CLEAR: begin
                            cmd.cnt_op = CNT_CLR;
                            cmd.emit   = 1'b1;
                            cmd.status = ST_OK;
                        end
                        KIND_WALK: begin
                            if (stat.empty) begin
                                cmd.emit   = 1'b1;
                                cmd.status = ST_EMPTY;
                            end else begin
                                cmd.idx_op = IDX_ZERO;
                                state_next = S_WALK_RD;
                            end
                        end
                        default: begin
                            cmd.emit   = 1'b1;
                            cmd.status = ST_OK;
                        end
                    endcase
                end
            end
            S_UP_RD: begin
                if (stat.up_done) begin
                    if (stat.out_free) begin
                        cmd.wr_en  = 1'b1;
                        cmd.wsel   = WA_POS;
                        cmd.cnt_op = CNT_INC;
                        cmd.emit   = 1'b1;
                        cmd.status = ST_OK;
                        state_next = S_IDLE;
                    end
                end else begin
                    cmd.rd_en  = 1'b1;
                    cmd.rsel   = RA_IDX_DN;
                    state_next = S_UP_WR;
                end
            end
            S_UP_WR: begin
                cmd.wr_en  = 1'b1;
                cmd.wsel   = WA_IDX;
                cmd.idx_op = IDX_DEC;
                state_next = S_UP_RD;
            end
            S_DN_RD: begin
                if (stat.dn_done) begin
                    if (stat.out_free) begin
                        cmd.cnt_op = CNT_DEC;
                        cmd.emit   = 1'b1;
                        cmd.status = ST_OK;
                        state_next = S_IDLE;
                    end
                end else begin
                    cmd.rd_en  = 1'b1;
                    cmd.rsel   = RA_IDX_UP;
                    state_next = S_DN_WR;
                end
            end
            S_DN_WR: begin
                cmd.wr_en  = 1'b1;
                cmd.wsel   = WA_IDX;
                cmd.idx_op = IDX_INC;
                state_next = S_DN_RD;
            end
            S_POP: begin
                if (stat.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_data = 1'b1;
                    cmd.status    = ST_OK;
                    state_next    = S_IDLE;
                end
            end
            S_WALK_RD: begin
                cmd.rd_en  = 1'b1;
                cmd.rsel   = RA_IDX;
                state_next = S_WALK_OUT;
            end
            S_WALK_OUT: begin
                if (stat.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_data = 1'b1;
                    cmd.status    = ST_OK;
                    cmd.last      = stat.walk_last;
                    if (stat.walk_last) begin
                        state_next = S_IDLE;
                    end else begin
                        cmd.idx_op = IDX_INC;
                        state_next = S_WALK_RD;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/ils_dp.sv @@
module ils_dp #(
    parameter int CAPACITY  = ils_pkg::DEF_CAPACITY,
    parameter int WORD_BITS = ils_pkg::DEF_WORD_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [ils_pkg::KIND_W-1:0]    s_kind,
    input  logic [ils_pkg::ITEM_W-1:0]    s_item,
    input  logic [ils_pkg::POS_W-1:0]     s_position,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [ils_pkg::ITEM_W-1:0]    m_item_out,
    output logic [ils_pkg::STATUS_W-1:0]  m_status,
    output logic [ils_pkg::COUNT_W-1:0]   m_count,
    output logic                          m_last,
    input  ils_pkg::ils_cmd_t             cmd,
    output ils_pkg::ils_stat_t            stat
);

    import ils_pkg::*;

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

    logic [KIND_W-1:0]    kind_reg;
    logic [WORD_BITS-1:0] item_reg;
    logic [POS_W-1:0]     pos_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic [CNT_W-1:0]     idx_reg;
    logic [CNT_W-1:0]     idx_next;
    logic                 m_valid_reg;
    logic                 m_valid_next;
    logic [ITEM_W-1:0]    m_item_reg;
    logic [STATUS_W-1:0]  m_status_reg;
    logic [COUNT_W-1:0]   m_count_reg;
    logic                 m_last_reg;

    logic [CMP_W-1:0]     count_ext;
    logic [CMP_W-1:0]     pos_ext;
    logic [CMP_W-1:0]     idx_ext;
    logic [CMP_W-1:0]     idx_inc_ext;
    logic [CMP_W-1:0]     count_next_ext;
    logic [CMP_W-1:0]     walk_lim;
    logic [CNT_W-1:0]     idx_inc;
    logic [CNT_W-1:0]     idx_dec;
    logic [CNT_W-1:0]     cnt_dec;

    logic                 wr_en;
    logic [ADDR_W-1:0]    wr_addr;
    logic [WORD_BITS-1:0] wr_data;
    logic [ADDR_W-1:0]    rd_addr;
    logic [WORD_BITS-1:0] rd_data;

    assign count_ext      = CMP_W'(count_reg);
    assign pos_ext        = CMP_W'(pos_reg);
    assign idx_ext        = CMP_W'(idx_reg);
    assign idx_inc        = idx_reg + CNT_W'(1);
    assign idx_dec        = idx_reg - CNT_W'(1);
    assign cnt_dec        = count_reg - CNT_W'(1);
    assign idx_inc_ext    = CMP_W'(idx_inc);
    assign count_next_ext = CMP_W'(count_next);
    assign walk_lim       = (count_ext > CMP_W'(MAX_RESULTS)) ? CMP_W'(MAX_RESULTS) : count_ext;

    assign stat.kind      = kind_reg;
    assign stat.full      = (count_reg == CNT_W'(CAPACITY));
    assign stat.empty     = (count_reg == '0);
    assign stat.pos_over  = (pos_ext > count_ext);
    assign stat.pos_out   = (pos_ext >= count_ext);
    assign stat.up_done   = (idx_ext == pos_ext);
    assign stat.dn_done   = (idx_inc == count_reg);
    assign stat.walk_last = (idx_inc_ext == walk_lim);
    assign stat.out_free  = !m_valid_reg || m_ready;

    always_comb begin
        wr_en   = cmd.wr_en;
        wr_data = item_reg;
        case (cmd.wsel)
            WA_COUNT: wr_addr = count_reg[ADDR_W-1:0];
            WA_POS:   wr_addr = pos_ext[ADDR_W-1:0];
            WA_IDX: begin
                wr_addr = idx_reg[ADDR_W-1:0];
                wr_data = rd_data;
            end
            default:  wr_addr = count_reg[ADDR_W-1:0];
        endcase
    end

    always_comb begin
        case (cmd.rsel)
            RA_IDX:    rd_addr = idx_reg[ADDR_W-1:0];
            RA_IDX_DN: rd_addr = idx_dec[ADDR_W-1:0];
            RA_IDX_UP: rd_addr = idx_inc[ADDR_W-1:0];
            RA_CNT_DN: rd_addr = cnt_dec[ADDR_W-1:0];
            default:   rd_addr = idx_reg[ADDR_W-1:0];
        endcase
    end

    always_comb begin
        case (cmd.cnt_op)
            CNT_HOLD: count_next = count_reg;
            CNT_INC:  count_next = count_reg + CNT_W'(1);
            CNT_DEC:  count_next = cnt_dec;
            CNT_CLR:  count_next = '0;
            default:  count_next = count_reg;
        endcase
    end

    always_comb begin
        case (cmd.idx_op)
            IDX_HOLD:     idx_next = idx_reg;
            IDX_LOAD_CNT: idx_next = count_reg;
            IDX_LOAD_POS: idx_next = pos_ext[CNT_W-1:0];
            IDX_ZERO:     idx_next = '0;
            IDX_INC:      idx_next = idx_inc;
            IDX_DEC:      idx_next = idx_dec;
            default:      idx_next = idx_reg;
        endcase
    end

    always_comb begin
        if (cmd.emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg <= idx_next;
        if (cmd.load_in) begin
            kind_reg <= s_kind;
            item_reg <= s_item[WORD_BITS-1:0];
            pos_reg  <= s_position;
        end
        if (cmd.emit) begin
            m_item_reg   <= cmd.emit_data ? ITEM_W'(rd_data) : '0;
            m_status_reg <= cmd.status;
            m_count_reg  <= count_next_ext[COUNT_W-1:0];
            m_last_reg   <= cmd.last;
        end
    end

    ils_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (CAPACITY)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (cmd.rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign m_valid    = m_valid_reg;
    assign m_item_out = m_item_reg;
    assign m_status   = m_status_reg;
    assign m_count    = m_count_reg;
    assign m_last     = m_last_reg;

endmodule
